// ----- rtl/u2c_pkg.sv -----
package u2c_pkg;

  localparam int unsigned MaxPayload = 8;
  localparam logic [7:0] StartByteReset = 8'h24;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_payload;
  } frame_t;

endpackage

// ----- rtl/u2c_ifs.sv -----
interface u2c_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface u2c_frame_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_payload;

  modport source(output valid, output frame_id, output frame_length, output frame_payload,
                 input ready);
  modport sink(input valid, input frame_id, input frame_length, input frame_payload,
               output ready);
endinterface

interface u2c_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/uart_to_can_frame_deframer.sv -----
// result: registered in the output stage when the parser consumes a frame's last item
// throughput: one item per cycle; the input register is freed in the cycle the parser
// consumes it, and a result waiting at the output stalls only an item that makes a frame
// reset: synchronous, active high; the parser returns to hunting for the start byte,
// the start byte register returns to 0x24 and no item or result is held
module uart_to_can_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  u2c_cfg_if.sink     cfg,
  u2c_byte_if.sink    rx,
  u2c_frame_if.source frame
);

  logic            start_byte;
  logic [7:0]      start_byte_reg;
  logic            in_valid;
  logic [7:0]      in_data;
  logic            emit;
  logic            can_load;
  logic            advance;
  u2c_pkg::frame_t frame_next;

  assign start_byte = 1'b1;
  assign cfg.ready  = start_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte_reg <= u2c_pkg::StartByteReset;
    end else if (cfg.valid) begin
      start_byte_reg <= cfg.data;
    end
  end

  // a held item moves on unless it makes a frame and the output is still full
  assign advance  = in_valid && (!emit || can_load);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_data <= rx.rx_byte;
    end
  end

  u2c_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte_reg),
    .step       (advance),
    .rx_data    (in_data),
    .emit       (emit),
    .frame_out  (frame_next)
  );

  u2c_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .frame_in (frame_next),
    .can_load (can_load),
    .frame    (frame)
  );

endmodule

// ----- rtl/u2c_parser.sv -----
module u2c_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      start_byte,
  input  logic            step,
  input  logic [7:0]      rx_data,
  output logic            emit,
  output u2c_pkg::frame_t frame_out
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ID_HIGH = 3'd1,
    PH_ID_LOW  = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_DATA    = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [10:0] id_accum, id_accum_next;
  logic [3:0]  length_reg, length_reg_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [63:0] payload_accum, payload_accum_next;
  logic [63:0] payload_merged;
  logic [3:0]  count_inc;

  always_comb begin
    payload_merged = payload_accum;
    // drop the byte into its lane, first byte lowest
    for (int i = 0; i < 8; i++) begin
      if (!byte_count[3] && byte_count[2:0] == 3'(i)) begin
        payload_merged[8*i +: 8] = rx_data;
      end
    end
  end

  assign count_inc = byte_count + 4'd1;

  always_comb begin
    phase_next         = phase;
    id_accum_next      = id_accum;
    length_reg_next    = length_reg;
    byte_count_next    = byte_count;
    payload_accum_next = payload_accum;
    emit               = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (rx_data == start_byte) begin
          phase_next = PH_ID_HIGH;
        end
      end
      PH_ID_HIGH: begin
        id_accum_next = {rx_data[2:0], 8'h00};
        phase_next    = PH_ID_LOW;
      end
      PH_ID_LOW: begin
        id_accum_next = id_accum | {3'b000, rx_data};
        phase_next    = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (rx_data == 8'd0 || rx_data > 8'(u2c_pkg::MaxPayload)) begin
          phase_next      = PH_HUNT;
          byte_count_next = 4'd0;
        end else begin
          length_reg_next    = rx_data[3:0];
          byte_count_next    = 4'd0;
          payload_accum_next = '0;
          phase_next         = PH_DATA;
        end
      end
      PH_DATA: begin
        payload_accum_next = payload_merged;
        byte_count_next    = count_inc;
        if (count_inc >= length_reg) begin
          emit            = 1'b1;
          phase_next      = PH_HUNT;
          byte_count_next = 4'd0;
        end
      end
      default: begin
        phase_next      = PH_HUNT;
        byte_count_next = 4'd0;
      end
    endcase
  end

  assign frame_out.frame_id      = id_accum;
  assign frame_out.frame_length  = length_reg;
  assign frame_out.frame_payload = payload_merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      id_accum      <= '0;
      length_reg    <= '0;
      byte_count    <= '0;
      payload_accum <= '0;
    end else if (step) begin
      phase         <= phase_next;
      id_accum      <= id_accum_next;
      length_reg    <= length_reg_next;
      byte_count    <= byte_count_next;
      payload_accum <= payload_accum_next;
    end
  end

endmodule

// ----- rtl/u2c_out_stage.sv -----
module u2c_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  u2c_pkg::frame_t frame_in,
  output logic            can_load,
  u2c_frame_if.source     frame
);

  logic            valid;
  u2c_pkg::frame_t frame_q;

  assign can_load = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (frame.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_q <= frame_in;
    end
  end

  assign frame.valid         = valid;
  assign frame.frame_id      = frame_q.frame_id;
  assign frame.frame_length  = frame_q.frame_length;
  assign frame.frame_payload = frame_q.frame_payload;

endmodule

// ----- rtl/u2c_checker.sv -----
module u2c_checker (
  input logic        clk,
  input logic        rst,
  input logic        frame_valid,
  input logic        frame_ready,
  input logic [10:0] frame_id,
  input logic [3:0]  frame_length,
  input logic [63:0] frame_payload
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !frame_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=>
      frame_valid && $stable({frame_id, frame_length, frame_payload}))
    else $error("stalled result changed or vanished");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> frame_length >= 4'd1 && frame_length <= 4'd8)
    else $error("frame length out of range");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame_payload >> {frame_length, 3'b000}) == 64'd0)
    else $error("payload bytes beyond length are not zero");

endmodule

bind uart_to_can_frame_deframer u2c_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .frame_valid   (frame.valid),
  .frame_ready   (frame.ready),
  .frame_id      (frame.frame_id),
  .frame_length  (frame.frame_length),
  .frame_payload (frame.frame_payload)
);
